// ===== hw/rtl/lprl_pkg.sv =====
// Shared types, constants and the match selection function for the route lookup.
// No dependencies; every other file in hw/rtl uses it by scoped name.
`default_nettype none

package lprl_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int GROUP_SIZE  = 8;
	localparam int GROUP_COUNT = TABLE_DEPTH / GROUP_SIZE;

	localparam int ADDR_W   = 32;
	localparam int INDEX_W  = 6;
	localparam int PREFIX_W = 6;
	localparam int IFC_W    = 8;
	localparam int COUNT_W  = 7;

	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	// One candidate route: a hit flag and the fields that ride with it.
	typedef struct packed {
		logic                hit;
		logic [PREFIX_W-1:0] prefix;
		logic [IFC_W-1:0]    ifc;
	} cand_t;

	typedef cand_t [GROUP_SIZE-1:0]  cand_grp_t;
	typedef cand_t [TABLE_DEPTH-1:0] cand_all_t;
	typedef cand_t [GROUP_COUNT-1:0] cand_win_t;

	// Longest prefix among hits; on a tie the lower slot keeps its place.
	// A result with no hit is all zeros.
	function automatic cand_t best_of(input cand_grp_t c);
		cand_t best;
		best = '0;
		for (int i = 0; i < GROUP_SIZE; i++) begin
			if (c[i].hit && (!best.hit || c[i].prefix > best.prefix)) begin
				best = c[i];
			end
		end
		return best;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lprl_table.sv =====
// Route table registers, lookup address stage and parallel match stage.
// Depends on lprl_pkg.
`default_nettype none

module lprl_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [lprl_pkg::INDEX_W-1:0]  wr_index,
	input  wire logic [lprl_pkg::ADDR_W-1:0]   wr_mask,
	input  wire logic [lprl_pkg::ADDR_W-1:0]   wr_network,
	input  wire logic [lprl_pkg::PREFIX_W-1:0] wr_prefix,
	input  wire logic [lprl_pkg::IFC_W-1:0]    wr_ifc,
	input  wire logic                         lookup_en,
	input  wire logic [lprl_pkg::ADDR_W-1:0]   lookup_addr,
	input  wire logic [lprl_pkg::COUNT_W-1:0]  route_count,
	output logic                              valid_s2,
	output lprl_pkg::cand_all_t               cand_s2
);

	logic [lprl_pkg::ADDR_W-1:0]   mask_q    [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::ADDR_W-1:0]   network_q [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::PREFIX_W-1:0] prefix_q  [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::IFC_W-1:0]    ifc_q     [lprl_pkg::TABLE_DEPTH];

	logic                        valid_s1;
	logic [lprl_pkg::ADDR_W-1:0] addr_s1;
	lprl_pkg::cand_all_t         cand_d;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mask_q[wr_index]    <= wr_mask;
			network_q[wr_index] <= wr_network;
			prefix_q[wr_index]  <= wr_prefix;
			ifc_q[wr_index]     <= wr_ifc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= lookup_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= lookup_addr;
		cand_s2 <= cand_d;
	end

	// Compare every slot at once; prefix and interface are captured here so a
	// write that lands later cannot change this item's answer.
	always_comb begin
		for (int i = 0; i < lprl_pkg::TABLE_DEPTH; i++) begin
			cand_d[i].hit    = (route_count > lprl_pkg::COUNT_W'(i))
			                   && ((addr_s1 & mask_q[i]) == network_q[i]);
			cand_d[i].prefix = prefix_q[i];
			cand_d[i].ifc    = ifc_q[i];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lprl_reduce.sv =====
// Two-level registered selection of the winning route: groups, then final.
// Depends on lprl_pkg.
`default_nettype none

module lprl_reduce (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s2,
	input  wire lprl_pkg::cand_all_t cand_s2,
	output logic                     valid_s4,
	output lprl_pkg::cand_t          best_s4
);

	logic                valid_s3;
	lprl_pkg::cand_win_t win_s3;
	lprl_pkg::cand_win_t win_d;
	lprl_pkg::cand_grp_t final_in;

	always_comb begin
		for (int g = 0; g < lprl_pkg::GROUP_COUNT; g++) begin
			win_d[g] = lprl_pkg::best_of(
				cand_s2[g*lprl_pkg::GROUP_SIZE +: lprl_pkg::GROUP_SIZE]);
		end
	end

	// Group winners keep slot order, so the lowest slot still wins a tie.
	always_comb begin
		final_in = '0;
		for (int g = 0; g < lprl_pkg::GROUP_COUNT; g++) begin
			final_in[g] = win_s3[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		win_s3  <= win_d;
		best_s4 <= lprl_pkg::best_of(final_in);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/longest_prefix_route_lookup.sv =====
// Top level of the longest-prefix route lookup.
// Depends on lprl_pkg, lprl_table and lprl_reduce.
`default_nettype none

// A new item is taken in every clock cycle; busy never rises. A write item
// updates the table at the edge that accepts it and gives no result, so a
// lookup in the next cycle already sees it. A lookup item passes the address
// register, the parallel compare of all 64 slots, group selection and final
// selection, and then gives its result with done high. Results come out in
// acceptance order at up to one per cycle. The receiver
// cannot stall. route_count is written through the cfg channel, which is
// always ready; values above 64 search the whole table. No clearing pass
// follows reset.
module longest_prefix_route_lookup (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [0:0]                    action,
	input  wire logic [lprl_pkg::INDEX_W-1:0]  entry_index,
	input  wire logic [lprl_pkg::ADDR_W-1:0]   entry_mask,
	input  wire logic [lprl_pkg::ADDR_W-1:0]   entry_network,
	input  wire logic [lprl_pkg::PREFIX_W-1:0] entry_prefix_length,
	input  wire logic [lprl_pkg::IFC_W-1:0]    entry_interface,
	input  wire logic [lprl_pkg::ADDR_W-1:0]   lookup_address,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lprl_pkg::COUNT_W-1:0]  cfg_data,
	output logic                               done,
	output logic                               route_found,
	output logic [lprl_pkg::IFC_W-1:0]         out_interface,
	output logic [lprl_pkg::PREFIX_W-1:0]      matched_prefix
);

	logic [lprl_pkg::COUNT_W-1:0] route_count_q;
	logic                         accept;
	logic                         is_lookup;
	logic                         valid_s2;
	lprl_pkg::cand_all_t          cand_s2;
	lprl_pkg::cand_t              best_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign is_lookup = (action == lprl_pkg::ACT_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			route_count_q <= cfg_data;
		end
	end

	lprl_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (accept && !is_lookup),
		.wr_index    (entry_index),
		.wr_mask     (entry_mask),
		.wr_network  (entry_network),
		.wr_prefix   (entry_prefix_length),
		.wr_ifc      (entry_interface),
		.lookup_en   (accept && is_lookup),
		.lookup_addr (lookup_address),
		.route_count (route_count_q),
		.valid_s2    (valid_s2),
		.cand_s2     (cand_s2)
	);

	lprl_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.cand_s2  (cand_s2),
		.valid_s4 (done),
		.best_s4  (best_s4)
	);

	assign route_found    = best_s4.hit;
	assign out_interface  = best_s4.ifc;
	assign matched_prefix = best_s4.prefix;

	a_lookup_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == lprl_pkg::ACT_LOOKUP) |-> ##4 done)
		else $error("lookup item produced no result");

	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && action == lprl_pkg::ACT_LOOKUP, 4))
		else $error("result without a lookup item");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !route_found) |-> (out_interface == '0 && matched_prefix == '0))
		else $error("miss result carries nonzero fields");

endmodule

`default_nettype wire

// ===== verif/longest_prefix_route_lookup_test.sv =====
// Self-checking testbench for longest_prefix_route_lookup: route writes, address lookups
// and route_count settings, with results predicted in the bench. Depends on lprl_pkg.
`timescale 1ns / 1ps

module longest_prefix_route_lookup_test;

	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 640;

	typedef struct {
		lprl_pkg::action_t             act;
		logic [lprl_pkg::INDEX_W-1:0]  slot;
		logic [lprl_pkg::ADDR_W-1:0]   mask;
		logic [lprl_pkg::ADDR_W-1:0]   net;
		logic [lprl_pkg::PREFIX_W-1:0] plen;
		logic [lprl_pkg::IFC_W-1:0]    ifc;
		logic [lprl_pkg::ADDR_W-1:0]   addr;
	} route_item_t;

	typedef struct packed {
		logic                          found;
		logic [lprl_pkg::IFC_W-1:0]    ifc;
		logic [lprl_pkg::PREFIX_W-1:0] plen;
	} route_answer_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [0:0]                    action = '0;
	logic [lprl_pkg::INDEX_W-1:0]  entry_index = '0;
	logic [lprl_pkg::ADDR_W-1:0]   entry_mask = '0;
	logic [lprl_pkg::ADDR_W-1:0]   entry_network = '0;
	logic [lprl_pkg::PREFIX_W-1:0] entry_prefix_length = '0;
	logic [lprl_pkg::IFC_W-1:0]    entry_interface = '0;
	logic [lprl_pkg::ADDR_W-1:0]   lookup_address = '0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [lprl_pkg::COUNT_W-1:0]  cfg_data = '0;
	logic                          done;
	logic                          route_found;
	logic [lprl_pkg::IFC_W-1:0]    out_interface;
	logic [lprl_pkg::PREFIX_W-1:0] matched_prefix;

	// predicted route table and count
	logic [lprl_pkg::ADDR_W-1:0]   tbl_mask [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::ADDR_W-1:0]   tbl_net [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::PREFIX_W-1:0] tbl_len [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::IFC_W-1:0]    tbl_ifc [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::COUNT_W-1:0]  tbl_count = '0;

	route_item_t   route_items [$];
	route_answer_t answers_due [$];
	route_item_t   cur;
	int            pushed_count = 0;
	int            taken_count = 0;
	int            fail_count = 0;
	int            gap_left = 0;
	int            gapless_left = 0;

	// stimulus-side view: which slots have been written, and address anchors
	logic [lprl_pkg::TABLE_DEPTH-1:0] slot_written = '0;
	logic [lprl_pkg::ADDR_W-1:0]      anchors [4];

	longest_prefix_route_lookup u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.action              (action),
		.entry_index         (entry_index),
		.entry_mask          (entry_mask),
		.entry_network       (entry_network),
		.entry_prefix_length (entry_prefix_length),
		.entry_interface     (entry_interface),
		.lookup_address      (lookup_address),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_data            (cfg_data),
		.done                (done),
		.route_found         (route_found),
		.out_interface       (out_interface),
		.matched_prefix      (matched_prefix)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic route_answer_t best_route(input logic [lprl_pkg::ADDR_W-1:0] addr);
		route_answer_t ans;
		int            limit;
		ans = '0;
		limit = (tbl_count > lprl_pkg::TABLE_DEPTH) ? lprl_pkg::TABLE_DEPTH : int'(tbl_count);
		for (int i = 0; i < limit; i++) begin
			if ((addr & tbl_mask[i]) == tbl_net[i]
					&& (!ans.found || tbl_len[i] > ans.plen)) begin
				ans.found = 1'b1;
				ans.plen  = tbl_len[i];
				ans.ifc   = tbl_ifc[i];
			end
		end
		return ans;
	endfunction

	// mostly short gaps, a few long ones, and now and then a gap-free stretch
	function automatic int next_gap();
		int r;
		if (gapless_left > 0) begin
			gapless_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			gapless_left = $urandom_range(20, 60);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// driver: present items from the queue, predict each one as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken_count++;
				if (cur.act == lprl_pkg::ACT_WRITE) begin
					tbl_mask[cur.slot] = cur.mask;
					tbl_net[cur.slot]  = cur.net;
					tbl_len[cur.slot]  = cur.plen;
					tbl_ifc[cur.slot]  = cur.ifc;
				end else begin
					answers_due.push_back(best_route(cur.addr));
				end
			end
			// hold the item while busy
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (route_items.size() != 0) begin
					cur = route_items.pop_front();
					action              <= cur.act;
					entry_index         <= cur.slot;
					entry_mask          <= cur.mask;
					entry_network       <= cur.net;
					entry_prefix_length <= cur.plen;
					entry_interface     <= cur.ifc;
					lookup_address      <= cur.addr;
					start               <= 1'b1;
					gap_left = next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	// monitor: every done pulse is one lookup answer
	always @(posedge clk) begin
		route_answer_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got found=%0b ifc=0x%0h prefix=%0d",
					$time, route_found, out_interface, matched_prefix);
				fail_count++;
			end else begin
				want = answers_due.pop_front();
				check_field("route_found", 32'(route_found), 32'(want.found));
				check_field("out_interface", 32'(out_interface), 32'(want.ifc));
				check_field("matched_prefix", 32'(matched_prefix), 32'(want.plen));
			end
		end
	end

	function automatic route_item_t scrambled_item();
		route_item_t it;
		it.act  = ($urandom_range(0, 1) == 0) ? lprl_pkg::ACT_WRITE : lprl_pkg::ACT_LOOKUP;
		it.slot = lprl_pkg::INDEX_W'($urandom_range(0, lprl_pkg::TABLE_DEPTH - 1));
		it.mask = $urandom;
		it.net  = $urandom;
		it.plen = lprl_pkg::PREFIX_W'($urandom_range(0, 63));
		it.ifc  = lprl_pkg::IFC_W'($urandom_range(0, 255));
		it.addr = $urandom;
		return it;
	endfunction

	function automatic void push_write(input int slot, input logic [lprl_pkg::ADDR_W-1:0] mask,
			input logic [lprl_pkg::ADDR_W-1:0] net, input int plen, input int ifc);
		route_item_t it;
		it = scrambled_item();
		it.act  = lprl_pkg::ACT_WRITE;
		it.slot = lprl_pkg::INDEX_W'(slot);
		it.mask = mask;
		it.net  = net;
		it.plen = lprl_pkg::PREFIX_W'(plen);
		it.ifc  = lprl_pkg::IFC_W'(ifc);
		route_items.push_back(it);
		slot_written[slot] = 1'b1;
		pushed_count++;
	endfunction

	function automatic void push_lookup(input logic [lprl_pkg::ADDR_W-1:0] addr);
		route_item_t it;
		it = scrambled_item();
		it.act  = lprl_pkg::ACT_LOOKUP;
		it.addr = addr;
		route_items.push_back(it);
		pushed_count++;
	endfunction

	// number of slots written contiguously from slot zero
	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < lprl_pkg::TABLE_DEPTH && slot_written[n])
			n++;
		return n;
	endfunction

	// mostly nested prefixes around a few anchors, some arbitrary noise routes
	function automatic void random_write(input int slot);
		int                          p;
		logic [lprl_pkg::ADDR_W-1:0] mask;
		logic [lprl_pkg::ADDR_W-1:0] net;
		int                          plen;
		p = $urandom_range(0, 32);
		if ($urandom_range(0, 99) < 85) begin
			mask = (p == 0) ? '0 : ~32'h0 << (32 - p);
			net  = anchors[$urandom_range(0, 3)] & mask;
			if (p > 0 && $urandom_range(0, 3) == 0)
				net ^= 32'h1 << (32 - $urandom_range(1, p));
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : p;
		end else begin
			mask = $urandom;
			net  = ($urandom_range(0, 1) == 0) ? ($urandom & mask) : $urandom;
			plen = $urandom_range(0, 63);
		end
		push_write(slot, mask, net, plen, $urandom_range(0, 255));
	endfunction

	function automatic void random_lookup();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			push_lookup(anchors[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 32)));
		else if (r < 92)
			push_lookup($urandom);
		else
			push_lookup(($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF);
	endfunction

	// wait until every item is taken and every answer has come, then let the pipe settle
	task automatic wait_idle();
		int n;
		n = 0;
		while (taken_count != pushed_count)
			@(posedge clk);
		while (answers_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (answers_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, answers_due.size());
			fail_count++;
			answers_due.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_route_count(input logic [lprl_pkg::COUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tbl_count = value;
		@(negedge clk);
	endtask

	initial begin
		int made;
		int n;
		int w;
		int r;
		logic [lprl_pkg::COUNT_W-1:0] cnt;

		foreach (anchors[k])
			anchors[k] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// count is zero after reset: nothing can match
		push_lookup(32'h0);
		push_lookup(32'hFFFF_FFFF);
		push_write(0, 32'h0, 32'h0, 0, 8'h01);                          // default route
		push_write(1, 32'hFF00_0000, 32'h0A00_0000, 8, 8'h02);
		push_write(2, 32'hFFFF_0000, 32'h0A01_0000, 16, 8'h03);
		push_write(3, 32'hFFFF_0000, 32'h0A01_0000, 16, 8'h04);         // tie, loses to slot 2
		push_write(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32, 8'hFF);
		push_write(5, 32'hFFFF_FF00, 32'h0A01_01FF, 24, 8'h05);         // network not masked
		push_write(6, 32'hF000_0000, 32'hC000_0000, 63, 8'h80);         // prefix above range
		push_write(7, 32'hFFFF_FFFF, 32'h0, 32, 8'h07);
		wait_idle();
		write_route_count(lprl_pkg::COUNT_W'(8));
		push_lookup(32'h0A01_0203);
		push_lookup(32'h0A01_01FF);
		push_lookup(32'hFFFF_FFFF);
		push_lookup(32'hC123_4567);
		push_lookup(32'h0);
		push_lookup(32'h7F00_0001);
		wait_idle();
		write_route_count(lprl_pkg::COUNT_W'(1));
		push_lookup(32'hFFFF_FFFF);
		push_write(0, 32'hFFFF_FFFF, 32'h0102_0304, 0, 8'h5A);
		push_lookup(32'h7F00_0001);                                     // no route
		push_lookup(32'h0102_0304);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 4) == 0)
				anchors[$urandom_range(0, 3)] = $urandom;
			w = written_prefix();
			r = $urandom_range(0, 9);
			if (w == lprl_pkg::TABLE_DEPTH && r < 2)
				cnt = lprl_pkg::COUNT_W'($urandom_range(lprl_pkg::TABLE_DEPTH + 1, 127));
			else if (r < 6)
				cnt = lprl_pkg::COUNT_W'(w);
			else
				cnt = lprl_pkg::COUNT_W'($urandom_range(0, w));
			write_route_count(cnt);
			n = $urandom_range(20, 80);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 35) begin
					w = written_prefix();
					if (w < lprl_pkg::TABLE_DEPTH && $urandom_range(0, 99) < 40)
						random_write(w);
					else
						random_write($urandom_range(0, lprl_pkg::TABLE_DEPTH - 1));
				end else begin
					random_lookup();
				end
			end
			made += n;
		end

		// fill the table, then sweep the count extremes
		for (int s = 0; s < lprl_pkg::TABLE_DEPTH; s++)
			if (!slot_written[s])
				random_write(s);
		foreach (anchors[k]) begin
			wait_idle();
			cnt = lprl_pkg::COUNT_W'((k == 0) ? lprl_pkg::TABLE_DEPTH : (k == 1) ? 127 :
				(k == 2) ? 0 : lprl_pkg::TABLE_DEPTH + 1);
			write_route_count(cnt);
			repeat (12) random_lookup();
		end

		wait_idle();
		if (fail_count == 0)
			$display("longest_prefix_route_lookup_test OK");
		else
			$display("longest_prefix_route_lookup_test NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("longest_prefix_route_lookup_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lprl_pkg.sv
hw/rtl/lprl_table.sv
hw/rtl/lprl_reduce.sv
hw/rtl/longest_prefix_route_lookup.sv
verif/longest_prefix_route_lookup_test.sv
